// ===== hw/rtl/touch_window_vote_release_assert.svh =====
// Assertion macros used by the touch window vote release core.
// Depends on the asserting module having ports named aclk and aresetn.
`ifndef TOUCH_WINDOW_VOTE_RELEASE_ASSERT_SVH
`define TOUCH_WINDOW_VOTE_RELEASE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TWVR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TWVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/twvr_pkg.sv =====
// Package for the touch window vote release block: widths, register codes,
// reset values and the configuration struct. No dependencies.
package twvr_pkg;

    localparam int unsigned LANE_MAX   = 8;
    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned CH_W       = 3;
    localparam int unsigned MASK_W     = 8;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned ROUND_W    = 8;
    localparam int unsigned CC_W       = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_THRESHOLD = 2'd0,
        REG_WINDOW_LEN     = 2'd1,
        REG_VOTE_THRESHOLD = 2'd2,
        REG_CHANNEL_COUNT  = 2'd3
    } cfg_reg_t;

    // Reset values; the vote threshold is 80 rounds times a quarter.
    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 12'd3500;
    localparam logic [ROUND_W-1:0]  WINDOW_LEN_RST     = 8'd80;
    localparam logic [COUNT_W-1:0]  VOTE_THRESHOLD_RST = 8'd20;
    localparam logic [CC_W-1:0]     CHANNEL_COUNT_RST  = 4'd8;

    // Decoded configuration seen by the vote core.
    typedef struct packed {
        logic [SAMPLE_W-1:0] high_threshold;
        logic [ROUND_W-1:0]  win;
        logic [COUNT_W-1:0]  vote_threshold;
        logic [CH_W-1:0]     last_ch;
        logic [MASK_W-1:0]   lane_mask;
    } cfg_t;

endpackage

// ===== hw/rtl/twvr_cfg_regs.sv =====
// Configuration registers of the touch window vote release block and their
// decode into the cfg_t struct. Depends on twvr_pkg.
module twvr_cfg_regs #(
    parameter int unsigned LANES = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [twvr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [twvr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output twvr_pkg::cfg_t                       cfg
);

    logic [twvr_pkg::SAMPLE_W-1:0] high_threshold_reg;
    logic [twvr_pkg::ROUND_W-1:0]  window_len_reg;
    logic [twvr_pkg::COUNT_W-1:0]  vote_threshold_reg;
    logic [twvr_pkg::CC_W-1:0]     channel_count_reg;
    logic [twvr_pkg::CC_W-1:0]     lanes_used;

    // Writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_threshold_reg <= twvr_pkg::HIGH_THRESHOLD_RST;
            window_len_reg     <= twvr_pkg::WINDOW_LEN_RST;
            vote_threshold_reg <= twvr_pkg::VOTE_THRESHOLD_RST;
            channel_count_reg  <= twvr_pkg::CHANNEL_COUNT_RST;
        end else if (cfg_valid) begin
            case (twvr_pkg::cfg_reg_t'(cfg_index))
                twvr_pkg::REG_HIGH_THRESHOLD: begin
                    high_threshold_reg <= cfg_data[twvr_pkg::SAMPLE_W-1:0];
                end
                twvr_pkg::REG_WINDOW_LEN: begin
                    window_len_reg <= cfg_data[twvr_pkg::ROUND_W-1:0];
                end
                twvr_pkg::REG_VOTE_THRESHOLD: begin
                    vote_threshold_reg <= cfg_data[twvr_pkg::COUNT_W-1:0];
                end
                twvr_pkg::REG_CHANNEL_COUNT: begin
                    channel_count_reg <= cfg_data[twvr_pkg::CC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the channel count to 1 .. LANES.
    always_comb begin
        lanes_used = channel_count_reg;
        if (lanes_used == '0) begin
            lanes_used = twvr_pkg::CC_W'(1);
        end
        if (lanes_used > twvr_pkg::CC_W'(LANES)) begin
            lanes_used = twvr_pkg::CC_W'(LANES);
        end
    end

    // Decoded view: a zero window length acts as one round.
    always_comb begin
        cfg.high_threshold = high_threshold_reg;
        cfg.win            = (window_len_reg == '0) ? twvr_pkg::ROUND_W'(1) : window_len_reg;
        cfg.vote_threshold = vote_threshold_reg;
        cfg.last_ch        = twvr_pkg::CH_W'(lanes_used - twvr_pkg::CC_W'(1));
        for (int i = 0; i < twvr_pkg::MASK_W; i++) begin
            cfg.lane_mask[i] = (twvr_pkg::CC_W'(i) < lanes_used);
        end
    end

endmodule

// ===== hw/rtl/twvr_vote_core.sv =====
// Per-channel high counters, round counter and touch/release decision.
// Depends on twvr_pkg and touch_window_vote_release_assert.svh.
`include "touch_window_vote_release_assert.svh"

module twvr_vote_core #(
    parameter int unsigned LANES = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  twvr_pkg::cfg_t                    cfg,
    input  logic                              step_valid,
    input  logic [twvr_pkg::SAMPLE_W-1:0]     sample,
    input  logic [twvr_pkg::CH_W-1:0]         ch,
    output logic                              res_valid,
    output logic [twvr_pkg::MASK_W-1:0]       touched,
    output logic [twvr_pkg::MASK_W-1:0]       released
);

    logic [twvr_pkg::COUNT_W-1:0] count_reg [LANES];
    logic [twvr_pkg::COUNT_W-1:0] count_next [LANES];
    logic [twvr_pkg::ROUND_W-1:0] round_reg;
    logic [twvr_pkg::ROUND_W-1:0] round_next;
    logic [twvr_pkg::ROUND_W-1:0] round_inc;
    logic [twvr_pkg::MASK_W-1:0]  prior_touched_reg;
    logic                         in_use;
    logic                         is_high;
    logic                         round_end;

    // Samples on channels outside the active range are dropped.
    assign in_use    = (ch <= cfg.last_ch);
    assign is_high   = (sample > cfg.high_threshold);
    assign round_end = step_valid && in_use && (ch == cfg.last_ch);
    assign round_inc = round_reg + twvr_pkg::ROUND_W'(1);
    assign res_valid = round_end && (round_inc >= cfg.win);

    // One saturating counter and one vote compare per lane.
    for (genvar i = 0; i < twvr_pkg::MASK_W; i++) begin : g_lane
        if (i < LANES) begin : g_used
            logic hit;
            assign hit = step_valid && in_use && is_high &&
                         (ch == twvr_pkg::CH_W'(i)) && (count_reg[i] != '1);
            assign count_next[i] = hit ? count_reg[i] + twvr_pkg::COUNT_W'(1)
                                       : count_reg[i];
            assign touched[i] = cfg.lane_mask[i] && (count_next[i] > cfg.vote_threshold);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    count_reg[i] <= '0;
                end else if (res_valid) begin
                    count_reg[i] <= '0;
                end else begin
                    count_reg[i] <= count_next[i];
                end
            end
        end else begin : g_unused
            assign touched[i] = 1'b0;
        end
    end

    assign released = prior_touched_reg & ~touched & cfg.lane_mask;

    // Round counter advances at each round end and clears at the end of a window.
    always_comb begin
        round_next = round_reg;
        if (res_valid) begin
            round_next = '0;
        end else if (round_end) begin
            round_next = round_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_reg         <= '0;
            prior_touched_reg <= '0;
        end else begin
            round_reg <= round_next;
            if (res_valid) begin
                prior_touched_reg <= touched;
            end
        end
    end

    // A channel is never touched and released in the same window.
    `TWVR_ASSERT_NOW(a_no_touch_and_release, res_valid, (touched & released) == '0,
        "channel both touched and released")
    // Only channels in use can appear in either mask.
    `TWVR_ASSERT_NOW(a_masks_in_use, res_valid,
        ((touched | released) & ~cfg.lane_mask) == '0, "mask bit outside active channels")
    // A finished window restarts the round count.
    `TWVR_ASSERT_NEXT(a_round_clears, res_valid, round_reg == '0,
        "round counter not cleared after window")
    // A window only ends on a transaction.
    `TWVR_ASSERT_NOW(a_result_needs_step, res_valid, step_valid,
        "result produced without an input transaction")

endmodule

// ===== hw/rtl/touch_window_vote_release.sv =====
// Touch window vote release block: top level with input and result registers.
// Depends on twvr_pkg, twvr_cfg_regs and twvr_vote_core.
//
// Usage:
//   s_ channel: one converter sample and its pad channel per transaction.
//     Samples arrive round-robin; a round ends on the highest channel in use.
//   m_ channel: after window_len rounds, one transaction carries the touched
//     and released masks, and all per-channel counts clear.
//   cfg channel: register index and data; writes always complete at once.
//     Write only while no transaction is in flight.
// Path: the sample ending a window passes from the input register through
//   the counter update and compare to the result register, which drives m_.
//   Rate: one sample per cycle while no stalled result blocks it, set by the
//   single counter update and compare stage between the two registers.
// Reset (aresetn low, synchronous): registers take their defaults, counts,
//   round counter and touched history clear, both channels go empty.
// Stall: while m_ready is low with a result held, one more sample is still
//   taken into the input register; s_ready then drops until m_ready returns.
module touch_window_vote_release #(
    parameter int unsigned NUM_CHANNELS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [twvr_pkg::SAMPLE_W-1:0]     s_sample,
    input  logic [twvr_pkg::CH_W-1:0]         s_channel_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [twvr_pkg::MASK_W-1:0]       m_touched_mask,
    output logic [twvr_pkg::MASK_W-1:0]       m_released_mask,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [twvr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [twvr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned LANES = (NUM_CHANNELS < twvr_pkg::LANE_MAX) ?
                                    NUM_CHANNELS : twvr_pkg::LANE_MAX;

    twvr_pkg::cfg_t                cfg;
    logic                          in_valid_reg;
    logic [twvr_pkg::SAMPLE_W-1:0] sample_reg;
    logic [twvr_pkg::CH_W-1:0]     ch_reg;
    logic                          step_fire;
    logic                          res_valid;
    logic [twvr_pkg::MASK_W-1:0]   touched;
    logic [twvr_pkg::MASK_W-1:0]   released;
    logic                          m_valid_reg;
    logic [twvr_pkg::MASK_W-1:0]   touched_reg;
    logic [twvr_pkg::MASK_W-1:0]   released_reg;

    twvr_cfg_regs #(
        .LANES (LANES)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held sample is processed when the result register can take a result.
    assign step_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample;
            ch_reg     <= s_channel_index;
        end
    end

    twvr_vote_core #(
        .LANES (LANES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step_valid (step_fire),
        .sample     (sample_reg),
        .ch         (ch_reg),
        .res_valid  (res_valid),
        .touched    (touched),
        .released   (released)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            touched_reg  <= touched;
            released_reg <= released;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_touched_mask  = touched_reg;
    assign m_released_mask = released_reg;

endmodule

// ===== test/touch_window_vote_release_tb.sv =====
// Self-checking testbench for touch_window_vote_release: directed and random
// sample streams with a scoreboard that predicts the touched and released masks.
// Depends on twvr_pkg and the touch_window_vote_release RTL.
module touch_window_vote_release_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 5000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [twvr_pkg::MASK_W-1:0] touched;
        logic [twvr_pkg::MASK_W-1:0] released;
    } vote_result_t;

    // Predicts the vote outcome of every window and checks results in order.
    class touch_vote_board;
        logic [twvr_pkg::SAMPLE_W-1:0] high_threshold;
        logic [twvr_pkg::ROUND_W-1:0]  window_len;
        logic [twvr_pkg::COUNT_W-1:0]  vote_threshold;
        logic [twvr_pkg::CC_W-1:0]     channel_count;
        logic [twvr_pkg::COUNT_W-1:0]  high_counts [twvr_pkg::LANE_MAX];
        logic [twvr_pkg::ROUND_W-1:0]  round_counter;
        logic [twvr_pkg::MASK_W-1:0]   prior_touched;
        vote_result_t                  expected_masks [$];
        int                            fails;

        function new();
            high_threshold = twvr_pkg::HIGH_THRESHOLD_RST;
            window_len     = twvr_pkg::WINDOW_LEN_RST;
            vote_threshold = twvr_pkg::VOTE_THRESHOLD_RST;
            channel_count  = twvr_pkg::CHANNEL_COUNT_RST;
            foreach (high_counts[i]) high_counts[i] = '0;
            round_counter  = '0;
            prior_touched  = '0;
            fails          = 0;
        endfunction

        function int lanes_in_use();
            int lanes;
            lanes = int'(channel_count);
            if (lanes < 1) lanes = 1;
            if (lanes > int'(twvr_pkg::LANE_MAX)) lanes = int'(twvr_pkg::LANE_MAX);
            return lanes;
        endfunction

        function int pending();
            return expected_masks.size();
        endfunction

        function void note_config(twvr_pkg::cfg_reg_t idx,
                                  logic [twvr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                twvr_pkg::REG_HIGH_THRESHOLD:
                    high_threshold = data[twvr_pkg::SAMPLE_W-1:0];
                twvr_pkg::REG_WINDOW_LEN:
                    window_len     = data[twvr_pkg::ROUND_W-1:0];
                twvr_pkg::REG_VOTE_THRESHOLD:
                    vote_threshold = data[twvr_pkg::COUNT_W-1:0];
                twvr_pkg::REG_CHANNEL_COUNT:
                    channel_count  = data[twvr_pkg::CC_W-1:0];
                default: ;
            endcase
        endfunction

        // Applies one accepted sample; a finished window queues its masks.
        function void note_sample(logic [twvr_pkg::SAMPLE_W-1:0] smp,
                                  logic [twvr_pkg::CH_W-1:0] ch);
            int lanes;
            int win;
            int lane_bits;
            vote_result_t outcome;
            lanes = lanes_in_use();
            win   = (window_len == 0) ? 1 : int'(window_len);
            if (ch >= lanes) return;
            if (smp > high_threshold && high_counts[ch] != 8'hFF)
                high_counts[ch] = high_counts[ch] + 1'b1;
            if (ch != lanes - 1) return;
            round_counter = round_counter + 1'b1;
            if (round_counter < win) return;
            outcome.touched = '0;
            for (int i = 0; i < lanes; i++) begin
                if (high_counts[i] > vote_threshold) outcome.touched[i] = 1'b1;
            end
            lane_bits        = (1 << lanes) - 1;
            outcome.released = prior_touched & ~outcome.touched &
                               lane_bits[twvr_pkg::MASK_W-1:0];
            expected_masks.push_back(outcome);
            prior_touched = outcome.touched;
            foreach (high_counts[i]) high_counts[i] = '0;
            round_counter = '0;
        endfunction

        // Printing stops after a while on a badly broken run; counting does not.
        task report(string what);
            fails++;
            if (fails <= PRINT_LIMIT) $display("mismatch: %s", what);
        endtask

        task check_result(logic [twvr_pkg::MASK_W-1:0] touched,
                          logic [twvr_pkg::MASK_W-1:0] released);
            vote_result_t want;
            if (expected_masks.size() == 0) begin
                report($sformatf("unexpected result touched=%h released=%h",
                                 touched, released));
            end else begin
                want = expected_masks.pop_front();
                if (touched !== want.touched)
                    report($sformatf("touched_mask got %h, want %h", touched, want.touched));
                if (released !== want.released)
                    report($sformatf("released_mask got %h, want %h",
                                     released, want.released));
            end
        endtask
    endclass

    logic                            aclk            = 1'b0;
    logic                            aresetn         = 1'b0;
    logic                            s_valid         = 1'b0;
    logic                            s_ready;
    logic [twvr_pkg::SAMPLE_W-1:0]   s_sample        = '0;
    logic [twvr_pkg::CH_W-1:0]       s_channel_index = '0;
    logic                            m_valid;
    logic                            m_ready         = 1'b0;
    logic [twvr_pkg::MASK_W-1:0]     m_touched_mask;
    logic [twvr_pkg::MASK_W-1:0]     m_released_mask;
    logic                            cfg_valid       = 1'b0;
    logic                            cfg_ready;
    logic [twvr_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [twvr_pkg::CFG_DATA_W-1:0] cfg_data        = '0;

    touch_vote_board board = new();

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_off_left      = 0;
    int quiet_cycles       = 0;
    logic [twvr_pkg::SAMPLE_W-1:0] cur_high_threshold = twvr_pkg::HIGH_THRESHOLD_RST;
    int high_pct [twvr_pkg::LANE_MAX];

    touch_window_vote_release #(
        .NUM_CHANNELS(8)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_channel_index (s_channel_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_touched_mask  (m_touched_mask),
        .m_released_mask (m_released_mask),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Clock.
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Result side: check each accepted transaction, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_touched_mask, m_released_mask);
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: too long without any transaction on any channel ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one sample, idling first at the current rate, and waits for it.
    task automatic send_sample(input logic [twvr_pkg::SAMPLE_W-1:0] smp,
                               input logic [twvr_pkg::CH_W-1:0] ch);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_sample        <= smp;
        s_channel_index <= ch;
        do @(posedge aclk); while (!s_ready);
        board.note_sample(smp, ch);
    endtask

    // Writes all four registers back to back; narrow registers get junk upper bits.
    task automatic apply_settings(input logic [twvr_pkg::SAMPLE_W-1:0] ht,
                                  input logic [twvr_pkg::ROUND_W-1:0] wl,
                                  input logic [twvr_pkg::COUNT_W-1:0] vt,
                                  input logic [twvr_pkg::CC_W-1:0] cc);
        twvr_pkg::cfg_reg_t              idx_list [4];
        logic [twvr_pkg::CFG_DATA_W-1:0] val_list [4];
        idx_list = '{twvr_pkg::REG_HIGH_THRESHOLD, twvr_pkg::REG_WINDOW_LEN,
                     twvr_pkg::REG_VOTE_THRESHOLD, twvr_pkg::REG_CHANNEL_COUNT};
        val_list = '{ht, {4'($urandom), wl}, {4'($urandom), vt}, {8'($urandom), cc}};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            do @(posedge aclk); while (!cfg_ready);
            board.note_config(idx_list[i], val_list[i]);
        end
        cfg_valid          <= 1'b0;
        cur_high_threshold = ht;
    endtask

    // Stops offering, waits for every expected result, then lets the pipe empty.
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // A high reading with the given chance, else a reading at or below threshold.
    function automatic logic [twvr_pkg::SAMPLE_W-1:0] pick_sample(int pct);
        if (cur_high_threshold != 12'hFFF && $urandom_range(99) < pct)
            return twvr_pkg::SAMPLE_W'($urandom_range(4095, cur_high_threshold + 1));
        return twvr_pkg::SAMPLE_W'($urandom_range(cur_high_threshold, 0));
    endfunction

    // Round-robin rounds with a fresh touch profile per window, plus some noise
    // samples and a few rounds with a channel missing.
    task automatic run_phase(input logic [twvr_pkg::SAMPLE_W-1:0] ht,
                             input logic [twvr_pkg::ROUND_W-1:0] wl,
                             input logic [twvr_pkg::COUNT_W-1:0] vt,
                             input logic [twvr_pkg::CC_W-1:0] cc,
                             input int snd_pct, input int rcv_pct, input int n_rounds);
        int lanes;
        int win;
        settle();
        apply_settings(ht, wl, vt, cc);
        sender_idle_pct    = snd_pct;
        receiver_stall_pct = rcv_pct;
        lanes = (cc < 1) ? 1 :
                ((cc > twvr_pkg::LANE_MAX) ? int'(twvr_pkg::LANE_MAX) : int'(cc));
        win   = (wl == 0) ? 1 : int'(wl);
        for (int r = 0; r < n_rounds; r++) begin
            if (r % win == 0) begin
                foreach (high_pct[i]) begin
                    case ($urandom_range(3))
                        0: high_pct[i] = 0;
                        1: high_pct[i] = 30;
                        2: high_pct[i] = 70;
                        default: high_pct[i] = 100;
                    endcase
                end
            end
            if ($urandom_range(9) == 0)
                send_sample(twvr_pkg::SAMPLE_W'($urandom_range(4095)),
                            twvr_pkg::CH_W'($urandom_range(twvr_pkg::LANE_MAX - 1)));
            for (int ch = 0; ch < lanes; ch++) begin
                if ($urandom_range(19) != 0)
                    send_sample(pick_sample(high_pct[ch]), twvr_pkg::CH_W'(ch));
            end
        end
    endtask

    // Main sequence.
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: threshold edges on all eight channels in a one-round window.
        apply_settings(12'd4094, 8'd1, 8'd0, 4'd8);
        send_sample(12'd4095, 3'd0);
        send_sample(12'd0,    3'd1);
        send_sample(12'd4094, 3'd2);
        send_sample(12'd4095, 3'd3);
        send_sample(12'd2730, 3'd4);
        send_sample(12'd1365, 3'd5);
        send_sample(12'd4095, 3'd6);
        send_sample(12'd4094, 3'd7);

        // Directed: channels out of use are ignored and drop out of the history,
        // then a touched channel goes low and is reported released.
        settle();
        apply_settings(12'd2047, 8'd1, 8'd0, 4'd3);
        send_sample(12'd4095, 3'd5);
        send_sample(12'd4095, 3'd3);
        send_sample(12'd2048, 3'd0);
        send_sample(12'd2047, 3'd1);
        send_sample(12'd4095, 3'd2);
        send_sample(12'd0,    3'd0);
        send_sample(12'd4095, 3'd1);
        send_sample(12'd0,    3'd2);

        // Directed: a long window cut short after one round ends on the next one.
        settle();
        apply_settings(12'd2047, 8'd10, 8'd0, 4'd3);
        send_sample(12'd3000, 3'd0);
        send_sample(12'd100,  3'd1);
        send_sample(12'd3000, 3'd2);
        settle();
        apply_settings(12'd2047, 8'd1, 8'd0, 4'd3);
        send_sample(12'd4095, 3'd0);
        send_sample(12'd0,    3'd2);

        // Random phases across idling modes and register settings.
        run_phase(12'd2048, 8'd2,   8'd0,   4'd4,  0,  0,  40);
        run_phase(12'd1000, 8'd3,   8'd1,   4'd8,  73, 0,  25);
        run_phase(12'd3500, 8'd1,   8'd0,   4'd1,  0,  73, 150);
        run_phase(12'd0,    8'd4,   8'd2,   4'd3,  12, 12, 40);
        run_phase(12'd4095, 8'd0,   8'd255, 4'd0,  12, 12, 30);
        run_phase(12'd100,  8'd5,   8'd3,   4'd15, 0,  73, 20);
        run_phase(12'd3000, 8'd2,   8'd1,   4'd6,  12, 12, 25);

        // Counts saturate: a long run of high samples on one channel without a
        // round end, then a one-round window closes it.
        settle();
        apply_settings(12'd0, 8'd255, 8'd254, 4'd2);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < 270; i++)
            send_sample(twvr_pkg::SAMPLE_W'($urandom_range(4095, 1)), 3'd0);
        settle();
        apply_settings(12'd0, 8'd1, 8'd254, 4'd2);
        send_sample(twvr_pkg::SAMPLE_W'($urandom_range(4095)), 3'd1);

        // Back pressure: the result side holds off while samples keep coming.
        settle();
        apply_settings(12'd0, 8'd1, 8'd0, 4'd1);
        hold_off_left = 300;
        for (int i = 0; i < 40; i++)
            send_sample(twvr_pkg::SAMPLE_W'($urandom_range(4095)), 3'd0);

        settle();
        if (board.fails == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/twvr_pkg.sv
hw/rtl/twvr_cfg_regs.sv
hw/rtl/twvr_vote_core.sv
hw/rtl/touch_window_vote_release.sv
test/touch_window_vote_release_tb.sv
